### src/rtc_bcd_to_unix_seconds_macros.svh
// assertion macros for the rtc snapshot to unix seconds converter
`ifndef RTC_BCD_TO_UNIX_SECONDS_MACROS_SVH
`define RTC_BCD_TO_UNIX_SECONDS_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RTCU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RTCU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RTCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/rtcu_pkg.sv
package rtcu_pkg;

    // time constants
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [17:0] SECS_PER_HOUR = 18'd3600;
    localparam logic [17:0] SECS_PER_MIN  = 18'd60;
    localparam logic [17:0] DAYS_PER_YEAR = 18'd365;

    // offsets from 1900 used by the year corrections
    localparam logic [8:0] EPOCH_YEAR_OFS = 9'd70;
    localparam logic [8:0] LEAP_BASE_OFS  = 9'd69;
    localparam logic [8:0] CENTURY_2000   = 9'd100;
    localparam logic [8:0] CENTURY_2100   = 9'd201;
    localparam logic [7:0] YY_HUNDRED     = 8'd100;

    // decoded snapshot handed from the decoder to the pipeline
    typedef struct packed {
        logic [6:0] sec;      // 0..85
        logic [6:0] min;      // 0..85
        logic [5:0] hr;       // 0..45
        logic [5:0] day;      // 0..45
        logic [4:0] mon;      // 0..25
        logic [8:0] y;        // years since 1900, 0..265
        logic       leap;     // leap row from the two-digit year
        logic       pre_epoch; // full year below 1970
    } dec_t;

    // nibble-wise bcd decode, invalid nibbles kept as they are
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        return ({4'b0, b[7:4]} * 8'd10) + {4'b0, b[3:0]};
    endfunction

    // cumulative days before the month, zero for months outside 1..12
    function automatic logic [8:0] cum_days(input logic leap, input logic [4:0] mon);
        logic [8:0] base;
        base = 9'd0;
        case (mon)
            5'd2:    base = 9'd31;
            5'd3:    base = 9'd59;
            5'd4:    base = 9'd90;
            5'd5:    base = 9'd120;
            5'd6:    base = 9'd151;
            5'd7:    base = 9'd181;
            5'd8:    base = 9'd212;
            5'd9:    base = 9'd243;
            5'd10:   base = 9'd273;
            5'd11:   base = 9'd304;
            5'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon >= 5'd3) && (mon <= 5'd12))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### src/rtcu_decode.sv
module rtcu_decode (
    input  logic [7:0]    second_reg,
    input  logic [7:0]    minute_reg,
    input  logic [7:0]    hour_reg,
    input  logic [7:0]    day_reg,
    input  logic [7:0]    month_reg,
    input  logic [7:0]    year_reg,
    output rtcu_pkg::dec_t dec
);
    import rtcu_pkg::*;

    logic [7:0] sec_w;
    logic [7:0] min_w;
    logic [7:0] hr_w;
    logic [7:0] day_w;
    logic [7:0] mon_w;
    logic [7:0] yy_w;

    // mask the register bytes and decode each as bcd
    always_comb
    begin
        sec_w = bcd_decode({1'b0, second_reg[6:0]});
        min_w = bcd_decode({1'b0, minute_reg[6:0]});
        hr_w  = bcd_decode({2'b0, hour_reg[5:0]});
        day_w = bcd_decode({2'b0, day_reg[5:0]});
        mon_w = bcd_decode({3'b0, month_reg[4:0]});
        yy_w  = bcd_decode(year_reg);
    end

    // century flag, leap row and epoch check
    always_comb
    begin
        dec.sec       = sec_w[6:0];
        dec.min       = min_w[6:0];
        dec.hr        = hr_w[5:0];
        dec.day       = day_w[5:0];
        dec.mon       = mon_w[4:0];
        dec.y         = month_reg[7] ? ({1'b0, yy_w} + CENTURY_2000) : {1'b0, yy_w};
        dec.leap      = (yy_w[1:0] == 2'b00) && (yy_w != YY_HUNDRED);
        dec.pre_epoch = dec.y < EPOCH_YEAR_OFS;
    end

endmodule

### src/rtc_bcd_to_unix_seconds.sv
// Converts one snapshot of the six raw real-time-clock bytes into seconds
// since 1970-01-01 per transfer. A new snapshot can be taken every cycle
// while the output side keeps taking, and the result passes through four
// registered stages: bcd decode, month table and year corrections, day
// count, and the multiply by seconds per day. Each stage has its own valid
// bit and holds only while the stage after it is full and stalled, so
// bubbles close up and back-pressure reaches in_ready only when all four
// stages hold data. Years before 1970 give zero and the count wraps modulo
// 2^32.
`include "rtc_bcd_to_unix_seconds_macros.svh"

module rtc_bcd_to_unix_seconds (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  second_reg,
    input  logic [7:0]  minute_reg,
    input  logic [7:0]  hour_reg,
    input  logic [7:0]  day_reg,
    input  logic [7:0]  month_reg,
    input  logic [7:0]  year_reg,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] unix_seconds
);
    import rtcu_pkg::*;

    // stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1: decoded snapshot
    dec_t dec_w;
    dec_t dec_reg;

    // stage 2: day of year and year terms
    logic signed [9:0]  yday_reg, yday_next;
    logic [7:0]         yoff_reg, yoff_next;
    logic [5:0]         q4_reg, q4_next;
    logic [1:0]         c100_reg, c100_next;
    logic               c400_reg, c400_next;
    logic [17:0]        hm_reg, hm_next;
    logic [6:0]         sec2_reg;
    logic               pre2_reg;

    // stage 3: days since epoch and time of day
    logic signed [17:0] days_reg, days_next;
    logic [17:0]        tod_reg, tod_next;
    logic               pre3_reg;

    // stage 4: output
    logic [31:0]        unix_seconds_reg, unix_seconds_next;

    logic [8:0] mdays_w;
    logic [8:0] yoff_w;
    logic [8:0] q4_w;

    rtcu_decode u_decode (
        .second_reg (second_reg),
        .minute_reg (minute_reg),
        .hour_reg   (hour_reg),
        .day_reg    (day_reg),
        .month_reg  (month_reg),
        .year_reg   (year_reg),
        .dec        (dec_w)
    );

    // per-stage enables, a stage loads when empty or when its successor moves
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // month table, year offsets and hours plus minutes
    always_comb
    begin
        mdays_w   = cum_days(dec_reg.leap, dec_reg.mon);
        yday_next = $signed({1'b0, mdays_w} + {4'b0, dec_reg.day} - 10'd1);
        yoff_w    = dec_reg.y - EPOCH_YEAR_OFS;
        yoff_next = yoff_w[7:0];
        q4_w      = (dec_reg.y - LEAP_BASE_OFS) >> 2;
        q4_next   = q4_w[5:0];
        if (dec_reg.y >= CENTURY_2100)
        begin
            c100_next = 2'd2;
        end
        else if (dec_reg.y > CENTURY_2000)
        begin
            c100_next = 2'd1;
        end
        else
        begin
            c100_next = 2'd0;
        end
        c400_next = dec_reg.y > CENTURY_2000;
        hm_next   = (18'(dec_reg.hr) * SECS_PER_HOUR) + (18'(dec_reg.min) * SECS_PER_MIN);
    end

    // day count since the epoch
    always_comb
    begin
        days_next = $signed({{8{yday_reg[9]}}, yday_reg}
                  + (18'(yoff_reg) * DAYS_PER_YEAR)
                  + {12'b0, q4_reg}
                  - {16'b0, c100_reg}
                  + {17'b0, c400_reg});
        tod_next  = hm_reg + {11'b0, sec2_reg};
    end

    // seconds, zero before 1970, wrapping modulo 2^32
    always_comb
    begin
        if (pre3_reg)
        begin
            unix_seconds_next = 32'd0;
        end
        else
        begin
            unix_seconds_next = ({{14{days_reg[17]}}, days_reg} * SECS_PER_DAY)
                              + {14'b0, tod_reg};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dec_reg <= dec_w;
        end
        if (en2)
        begin
            yday_reg <= yday_next;
            yoff_reg <= yoff_next;
            q4_reg   <= q4_next;
            c100_reg <= c100_next;
            c400_reg <= c400_next;
            hm_reg   <= hm_next;
            sec2_reg <= dec_reg.sec;
            pre2_reg <= dec_reg.pre_epoch;
        end
        if (en3)
        begin
            days_reg <= days_next;
            tod_reg  <= tod_next;
            pre3_reg <= pre2_reg;
        end
        if (en4)
        begin
            unix_seconds_reg <= unix_seconds_next;
        end
    end

    assign out_valid    = v4_reg;
    assign unix_seconds = unix_seconds_reg;

    // checks
    `RTCU_ASSERT_IMPL(a_full_when_blocked, clk, rst_n, !in_ready, v1_reg && v2_reg && v3_reg && v4_reg, "input blocked with a stage empty")
    `RTCU_ASSERT_NEXT(a_stage3_moves_on, clk, rst_n, v3_reg && en4, out_valid, "stage 3 item lost on its way out")
    `RTCU_ASSERT_IMPL(a_yday_range, clk, rst_n, v2_reg, (yday_reg >= -10'sd1) && (yday_reg <= 10'sd380), "day of year out of range")
    `RTCU_ASSERT_IMPL(a_days_range, clk, rst_n, v3_reg && !pre3_reg, (days_reg >= -18'sd1) && (days_reg <= 18'sd71700), "day count out of range")

endmodule

### tb/rtc_bcd_to_unix_seconds_check.sv
`timescale 1ns / 100ps

module rtc_bcd_to_unix_seconds_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  second_reg,
    input  logic [7:0]  minute_reg,
    input  logic [7:0]  hour_reg,
    input  logic [7:0]  day_reg,
    input  logic [7:0]  month_reg,
    input  logic [7:0]  year_reg,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] unix_seconds,
    output int          errors,
    output int          outstanding
);

    localparam logic [31:0] DAY_SECS  = 32'd86400;
    localparam logic [31:0] YEAR_SECS = 32'd31536000;

    logic [31:0] pending_seconds[$];
    int          mismatch_count = 0;

    assign errors = mismatch_count;

    // nibble-wise decode, nibbles above nine pass straight through
    function automatic logic [31:0] bcd_value(input logic [7:0] b);
        return {28'd0, b[7:4]} * 32'd10 + {28'd0, b[3:0]};
    endfunction

    // days in the year before the first of the month
    function automatic logic [31:0] days_before_month(input logic [31:0] mon,
                                                      input logic leap);
        logic [31:0] days;
        case (mon)
            32'd2:   days = 32'd31;
            32'd3:   days = 32'd59;
            32'd4:   days = 32'd90;
            32'd5:   days = 32'd120;
            32'd6:   days = 32'd151;
            32'd7:   days = 32'd181;
            32'd8:   days = 32'd212;
            32'd9:   days = 32'd243;
            32'd10:  days = 32'd273;
            32'd11:  days = 32'd304;
            32'd12:  days = 32'd334;
            default: days = 32'd0;
        endcase
        if (leap && mon >= 32'd3 && mon <= 32'd12)
        begin
            days = days + 32'd1;
        end
        return days;
    endfunction

    // seconds since the epoch for one register snapshot, modulo 2^32
    function automatic logic [31:0] epoch_seconds(input logic [7:0] sec_b,
                                                  input logic [7:0] min_b,
                                                  input logic [7:0] hr_b,
                                                  input logic [7:0] day_b,
                                                  input logic [7:0] mon_b,
                                                  input logic [7:0] year_b);
        logic [31:0] secs;
        logic [31:0] mins;
        logic [31:0] hrs;
        logic [31:0] mday;
        logic [31:0] mon;
        logic [31:0] yy;
        logic [31:0] full_year;
        logic [31:0] y;
        logic [31:0] yday_m1;
        logic        leap;
        secs      = bcd_value(sec_b & 8'h7F);
        mins      = bcd_value(min_b & 8'h7F);
        hrs       = bcd_value(hr_b & 8'h3F);
        mday      = bcd_value(day_b & 8'h3F);
        mon       = bcd_value(mon_b & 8'h1F);
        yy        = bcd_value(year_b);
        full_year = (mon_b[7] ? 32'd2000 : 32'd1900) + yy;
        if (full_year < 32'd1970)
        begin
            return 32'd0;
        end
        // leap row taken from the two-digit year only
        leap = ((yy % 32'd4 == 32'd0) && (yy % 32'd100 != 32'd0)) ||
               (yy % 32'd400 == 32'd0);
        yday_m1 = ((mon <= 32'd12) ? days_before_month(mon, leap) : 32'd0)
                  + mday - 32'd1;
        y = full_year - 32'd1900;
        return secs + mins * 32'd60 + hrs * 32'd3600 + yday_m1 * DAY_SECS
               + (y - 32'd70) * YEAR_SECS
               + ((y - 32'd69) / 32'd4) * DAY_SECS
               - ((y - 32'd1) / 32'd100) * DAY_SECS
               + ((y + 32'd299) / 32'd400) * DAY_SECS;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %0d (0x%08h), expected %0d (0x%08h)",
                 $realtime, what, got, got, want, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // predict on each input transfer, compare on each output transfer
    always @(posedge clk)
    begin : watch
        logic [31:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_seconds.push_back(epoch_seconds(second_reg, minute_reg,
                                                        hour_reg, day_reg,
                                                        month_reg, year_reg));
            end
            if (out_valid && out_ready)
            begin
                if (pending_seconds.size() == 0)
                begin
                    report_mismatch("result with nothing pending", unix_seconds,
                                    32'd0);
                end
                else
                begin
                    want = pending_seconds.pop_front();
                    if (unix_seconds !== want)
                    begin
                        report_mismatch("unix_seconds", unix_seconds, want);
                    end
                end
            end
            outstanding <= pending_seconds.size();
        end
    end

endmodule

### tb/rtc_bcd_to_unix_seconds_test.sv
`timescale 1ns / 100ps

module rtc_bcd_to_unix_seconds_test;

    localparam int RANDOM_ITEMS = 1400;
    localparam int TAIL_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  second_reg;
    logic [7:0]  minute_reg;
    logic [7:0]  hour_reg;
    logic [7:0]  day_reg;
    logic [7:0]  month_reg;
    logic [7:0]  year_reg;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] unix_seconds;
    int          errors;
    int          outstanding;
    int          cycle_count = 0;
    bit          quiet_tail  = 1'b0;

    rtc_bcd_to_unix_seconds uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .second_reg   (second_reg),
        .minute_reg   (minute_reg),
        .hour_reg     (hour_reg),
        .day_reg      (day_reg),
        .month_reg    (month_reg),
        .year_reg     (year_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .unix_seconds (unix_seconds)
    );

    rtc_bcd_to_unix_seconds_check checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .second_reg   (second_reg),
        .minute_reg   (minute_reg),
        .hour_reg     (hour_reg),
        .day_reg      (day_reg),
        .month_reg    (month_reg),
        .year_reg     (year_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .unix_seconds (unix_seconds),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rtc_bcd_to_unix_seconds_test: errors");
            $finish;
        end
    end

    // output side: random stall bursts, none in the tail
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] to_bcd(input int n);
        int packed_val;
        packed_val = ((n / 10) << 4) | (n % 10);
        return packed_val[7:0];
    endfunction

    // present one snapshot and hold it until the transfer
    task automatic offer_snapshot(input logic [7:0] s, input logic [7:0] m,
                                  input logic [7:0] h, input logic [7:0] d,
                                  input logic [7:0] mo, input logic [7:0] yr);
        in_valid   <= 1'b1;
        second_reg <= s;
        minute_reg <= m;
        hour_reg   <= h;
        day_reg    <= d;
        month_reg  <= mo;
        year_reg   <= yr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stop sending until every prediction has been matched
    task automatic drain_results;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin : stimulus
        logic [7:0] s;
        logic [7:0] m;
        logic [7:0] h;
        logic [7:0] d;
        logic [7:0] mo;
        logic [7:0] yr;
        int         kind;
        bit         gaps_on;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        second_reg <= 8'h00;
        minute_reg <= 8'h00;
        hour_reg   <= 8'h00;
        day_reg    <= 8'h00;
        month_reg  <= 8'h00;
        year_reg   <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: epoch edges, leap rows, odd months, day zero, wrap
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // 1900, zero
        offer_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69); // 1969 end
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70); // epoch
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70); // day zero
        offer_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99); // 1999 end
        offer_snapshot(8'h00, 8'h00, 8'h12, 8'h29, 8'h82, 8'h00); // 2000 feb 29
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h83, 8'h00); // 2000 mar 1
        offer_snapshot(8'h30, 8'h15, 8'h08, 8'h01, 8'h83, 8'h23); // non-leap mar
        offer_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h92, 8'h24); // 2024 end
        offer_snapshot(8'h07, 8'h14, 8'h03, 8'h19, 8'h81, 8'h38); // 2^31 - 1
        offer_snapshot(8'h15, 8'h28, 8'h06, 8'h07, 8'h82, 8'hA6); // 2106 wrap
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h83, 8'hA0); // 2100 no leap
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h15, 8'h80, 8'h50); // month zero
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h15, 8'h93, 8'h50); // month 13
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h15, 8'h9F, 8'h50); // month 25
        offer_snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF); // all ones
        offer_snapshot(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'hFF); // 1900s, ff
        offer_snapshot(8'hD9, 8'hD9, 8'hE3, 8'hF1, 8'hF2, 8'h88); // ignored bits
        offer_snapshot(8'h5F, 8'h6A, 8'h2C, 8'h1B, 8'h8B, 8'h4E); // bad nibbles
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h81, 8'h00); // 2000 jan 1
        offer_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h81, 8'h00); // leap day 0
        offer_snapshot(8'h80, 8'h80, 8'hC0, 8'hC0, 8'h60, 8'h70); // flags only
        drain_results();

        // random: mostly well-formed dates, some raw bytes
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
            gaps_on    = ((n / 150) % 3) != 2;
            kind       = $urandom_range(0, 99);
            if (kind < 25)
            begin
                s  = 8'($urandom);
                m  = 8'($urandom);
                h  = 8'($urandom);
                d  = 8'($urandom);
                mo = 8'($urandom);
                yr = 8'($urandom);
            end
            else
            begin
                s  = to_bcd($urandom_range(0, 59));
                m  = to_bcd($urandom_range(0, 59));
                h  = to_bcd($urandom_range(0, 23));
                d  = to_bcd($urandom_range(1, 31));
                mo = to_bcd($urandom_range(1, 12));
                if ($urandom_range(0, 1) == 1)
                begin
                    mo[7] = 1'b1;
                    yr    = to_bcd($urandom_range(0, 99));
                end
                else
                begin
                    yr = to_bcd(($urandom_range(0, 9) == 0) ?
                                $urandom_range(0, 69) : $urandom_range(70, 99));
                end
                // flags the block must mask away
                if (kind >= 75)
                begin
                    s[7]     = 1'($urandom);
                    m[7]     = 1'($urandom);
                    h[7:6]   = 2'($urandom);
                    d[7:6]   = 2'($urandom);
                    mo[6:5]  = 2'($urandom);
                end
            end
            offer_snapshot(s, m, h, d, mo, yr);
            if (n == RANDOM_ITEMS / 2)
            begin
                drain_results();
            end
            else if (gaps_on && !quiet_tail && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end

        // wrap up once nothing is pending and the pipeline has settled
        drain_results();
        repeat (12) @(posedge clk);
        if (errors == 0)
        begin
            $display("rtc_bcd_to_unix_seconds_test: clean");
        end
        else
        begin
            $display("rtc_bcd_to_unix_seconds_test: errors");
        end
        $finish;
    end

endmodule

### rtc_bcd_to_unix_seconds.f
+incdir+src
src/rtcu_pkg.sv
src/rtcu_decode.sv
src/rtc_bcd_to_unix_seconds.sv
tb/rtc_bcd_to_unix_seconds_check.sv
tb/rtc_bcd_to_unix_seconds_test.sv
